### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### rtl/core/psms_pkg.sv
// ----------------------------------------------------------------------------
// Packed special matrix store package
// Sizes, codes and word types shared by the matrix store modules.
// ----------------------------------------------------------------------------
`default_nettype none

package psms_pkg;

    localparam int MAX_DIM    = 16;
    localparam int VALUE_BITS = 32;
    localparam int ORDER_W    = 5;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(DEPTH);
    // Room for the intermediate sums of the index arithmetic.
    localparam int CALC_W     = ADDR_W + 2;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic REG_KIND  = 1'b0;
    localparam logic REG_ORDER = 1'b1;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_FULL  = 3'd1,
        KIND_DIAG  = 3'd2,
        KIND_LOWER = 3'd3,
        KIND_UPPER = 3'd4,
        KIND_SYM   = 3'd5,
        KIND_TRI   = 3'd6,
        KIND_TOEP  = 3'd7
    } kind_e;

    typedef struct packed {
        logic                         op;
        logic [ORDER_W-1:0]           row;
        logic [ORDER_W-1:0]           col;
        logic signed [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] read_value;
        logic                         stored;
        logic                         range_error;
    } rsp_t;

    // Outcome of the index mapping for one word.
    typedef struct packed {
        logic              range_err;
        logic              kept;
        logic [ADDR_W-1:0] addr;
    } map_t;

endpackage

`default_nettype wire

### rtl/core/psms_map.sv
// ----------------------------------------------------------------------------
// Packed index mapper
// Turns a 1-based row and column into a packed store address for the kind.
// ----------------------------------------------------------------------------
`default_nettype none

module psms_map
    import psms_pkg::*;
(
    input  wire logic [ORDER_W-1:0] row,
    input  wire logic [ORDER_W-1:0] col,
    input  wire kind_e              kind,
    input  wire logic [ORDER_W-1:0] order,
    output map_t                    map
);

    logic [ORDER_W-1:0] n;
    logic [ORDER_W-1:0] row_m1;
    logic [ORDER_W-1:0] col_m1;
    logic [CALC_W-1:0]  iw;
    logic [CALC_W-1:0]  jw;
    logic [CALC_W-1:0]  nw;
    logic [CALC_W-1:0]  tri_i;
    logic [CALC_W-1:0]  tri_j;
    logic [CALC_W-1:0]  prod_in;
    logic [CALC_W-1:0]  idx;
    logic               hit;
    logic               range_err;

    always_comb
    begin
        n = (order > ORDER_W'(MAX_DIM)) ? ORDER_W'(MAX_DIM) : order;
        range_err = (row == '0) || (col == '0) || (row > n) || (col > n);

        row_m1 = row - ORDER_W'(1);
        col_m1 = col - ORDER_W'(1);
        iw     = CALC_W'(row_m1[IDX_W-1:0]);
        jw     = CALC_W'(col_m1[IDX_W-1:0]);
        nw     = CALC_W'(n);

        // Triangular numbers give the start of each packed row.
        tri_i   = (iw * (iw + CALC_W'(1))) >> 1;
        tri_j   = (jw * (jw + CALC_W'(1))) >> 1;
        prod_in = iw * nw;

        hit = 1'b0;
        idx = '0;
        unique case (kind)
            KIND_FULL:
            begin
                hit = 1'b1;
                idx = prod_in + jw;
            end
            KIND_DIAG:
            begin
                hit = (iw == jw);
                idx = iw;
            end
            KIND_LOWER:
            begin
                hit = (iw >= jw);
                idx = tri_i + jw;
            end
            KIND_UPPER:
            begin
                hit = (iw <= jw);
                idx = prod_in - tri_i + jw;
            end
            KIND_SYM:
            begin
                hit = 1'b1;
                idx = (iw >= jw) ? (tri_i + jw) : (tri_j + iw);
            end
            KIND_TRI:
            begin
                if (jw == iw + CALC_W'(1))
                begin
                    hit = 1'b1;
                    idx = iw;
                end
                else if (jw == iw)
                begin
                    hit = 1'b1;
                    idx = nw - CALC_W'(1) + iw;
                end
                else if (iw == jw + CALC_W'(1))
                begin
                    hit = 1'b1;
                    idx = (nw << 1) - CALC_W'(1) + jw;
                end
            end
            KIND_TOEP:
            begin
                hit = 1'b1;
                idx = (jw >= iw) ? (jw - iw) : (nw - CALC_W'(1) + iw - jw);
            end
            KIND_NONE:
            begin
                hit = 1'b0;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase

        map.range_err = range_err;
        map.kept      = !range_err && hit && (idx < CALC_W'(DEPTH));
        map.addr      = idx[ADDR_W-1:0];
    end

endmodule

`default_nettype wire

### rtl/core/psms_store.sv
// ----------------------------------------------------------------------------
// Packed element store
// Single-port element memory with per-entry written flags and a read register.
// ----------------------------------------------------------------------------
`default_nettype none

module psms_store
    import psms_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic                         rd_en,
    input  wire logic [ADDR_W-1:0]            addr,
    input  wire logic signed [VALUE_BITS-1:0] wdata,
    output logic signed [VALUE_BITS-1:0]      rdata
);

    logic [VALUE_BITS-1:0] store_mem [DEPTH];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  rd_hit_reg;
    logic                  rd_hit_next;
    logic [DEPTH-1:0]      written_reg;
    logic [DEPTH-1:0]      written_next;

    // An entry never written since reset reads as zero.
    always_comb
    begin
        written_next = written_reg;
        rd_hit_next  = rd_hit_reg;
        if (wr_en)
        begin
            written_next[addr] = 1'b1;
        end
        if (rd_en)
        begin
            rd_hit_next = written_reg[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            written_reg <= written_next;
            rd_hit_reg  <= rd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[addr];
        end
    end

    assign rdata = rd_hit_reg ? $signed(rd_data_reg) : '0;

endmodule

`default_nettype wire

### rtl/core/packed_special_matrix_store_top.sv
// ----------------------------------------------------------------------------
// Packed special matrix store
// Square matrix held in packed form, served one element access per word.
// ----------------------------------------------------------------------------
// The block keeps one square matrix of up to 16 by 16 signed 32-bit elements
// in a single 256-entry memory and answers one read or write word, addressed
// by 1-based row and column, with exactly one response word. The kind
// register selects the packing (full, diagonal, lower, upper, symmetric,
// tridiagonal or Toeplitz) and the order register the dimension in use.
// Positions the kind does not keep read as zero and ignore writes; a row or
// column outside 1..order (order capped at 16) raises range_error and
// touches nothing. A new request word is taken every clock cycle, but a
// stalled response holds the request register, which in turn holds intake
// once it is full. Each word passes the request register, which holds it
// while the packed address is worked out, and then the response register,
// loaded together with the registered read data of the single memory port,
// which offers the response word. The memory reads as all zero right after
// reset through per-entry written flags, so no clearing pass is needed.
// Kind and order may be changed only while no word is in flight; the
// memory contents are kept and reread under the new packing.
`default_nettype none

module packed_special_matrix_store_top
    import psms_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Request channel.
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire req_t               req,
    // Response channel.
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output rsp_t                    rsp,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    kind_e              kind_reg;
    kind_e              kind_next;
    logic [ORDER_W-1:0] order_reg;
    logic [ORDER_W-1:0] order_next;

    req_t               req_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               stored_reg;
    logic               range_error_reg;
    logic               rd_sel_reg;

    logic               cfg_wr;
    logic               advance;
    logic               accept;
    logic               fire;
    logic               wr_en;
    logic               rd_en;
    map_t               map;
    logic signed [VALUE_BITS-1:0] rdata;

    // ------------------------------------------------------------------
    // Configuration registers. Word-aligned: paddr[2] picks the register.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        kind_next  = kind_reg;
        order_next = order_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_KIND:  kind_next  = kind_e'(pwdata[2:0]);
                REG_ORDER: order_next = pwdata[ORDER_W-1:0];
                default:   kind_next  = kind_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_KIND:  prdata = PDATA_W'(kind_reg);
            REG_ORDER: prdata = PDATA_W'(order_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_FULL;
            order_reg <= ORDER_W'(MAX_DIM);
        end
        else
        begin
            kind_reg  <= kind_next;
            order_reg <= order_next;
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The pipeline moves whenever the response register is
    // free or being emptied, so a waiting response never blocks intake
    // while the request register is empty.
    // ------------------------------------------------------------------
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || advance;
    assign accept    = req_valid && req_ready;
    assign fire      = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next  = accept || (s1_valid_reg && !advance);
        rsp_valid_next = fire || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

    // ------------------------------------------------------------------
    // Address mapping and memory access.
    // ------------------------------------------------------------------
    psms_map u_map (
        .row   (req_reg.row),
        .col   (req_reg.col),
        .kind  (kind_reg),
        .order (order_reg),
        .map   (map)
    );

    assign wr_en = fire && map.kept && (req_reg.op == OP_WRITE);
    assign rd_en = fire && map.kept && (req_reg.op == OP_READ);

    psms_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (wr_en),
        .rd_en (rd_en),
        .addr  (map.addr),
        .wdata (req_reg.value),
        .rdata (rdata)
    );

    // Response flags travel alongside the registered memory read.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            stored_reg      <= map.kept;
            range_error_reg <= map.range_err;
            rd_sel_reg      <= rd_en;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign rsp.read_value   = rd_sel_reg ? rdata : '0;
    assign rsp.stored       = stored_reg;
    assign rsp.range_error  = range_error_reg;

endmodule

`default_nettype wire

### rtl/core/psms_checker.sv
// ----------------------------------------------------------------------------
// Matrix store port checker
// Watches the request and response channels of the matrix store top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module psms_checker
    import psms_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    // An out-of-range access never reports a kept position or data.
    `ASSERT_IMP(a_range_clean, clk, rst_n, rsp_valid && rsp.range_error, !rsp.stored && rsp.read_value == '0)

    // A position that is not kept always reads as zero.
    `ASSERT_IMP(a_unkept_zero, clk, rst_n, rsp_valid && !rsp.stored, rsp.read_value == '0)

    // A request word offered with no response pending is taken.
    `ASSERT_IMP(a_ready_when_empty, clk, rst_n, req_valid && !rsp_valid, req_ready)

    // A stalled response word holds.
    `ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind packed_special_matrix_store_top psms_checker u_psms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
